>>> rtl/t8pc_pkg.sv
// Package for the prescaled 8-bit CTC timer: item and result types,
// bus address map, opcodes, modes and the prescaler divisor table.
// No dependencies.
package t8pc_pkg;

	// Opcodes of an input item
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_ACK   = 2'd3;

	// Register addresses in data space
	localparam logic [7:0] ADDR_FLAGS  = 8'h35;
	localparam logic [7:0] ADDR_CTRL_A = 8'h44;
	localparam logic [7:0] ADDR_CTRL_B = 8'h45;
	localparam logic [7:0] ADDR_COUNT  = 8'h46;
	localparam logic [7:0] ADDR_CMP_A  = 8'h47;
	localparam logic [7:0] ADDR_CMP_B  = 8'h48;
	localparam logic [7:0] ADDR_MASK   = 8'h6E;

	// Storage masks of the control registers
	localparam logic [7:0] CTRL_A_KEEP = 8'hF3;
	localparam logic [7:0] CTRL_B_KEEP = 8'hCF;

	// Counting modes
	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_CTC    = 3'd2;

	// Interrupt sources, also the bit positions in flags, mask and pending
	localparam logic [1:0] SRC_OVF  = 2'd0;
	localparam logic [1:0] SRC_CMPA = 2'd1;
	localparam logic [1:0] SRC_CMPB = 2'd2;

	localparam int IRQ_N   = 3;
	localparam int PRE_W   = 11;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] address;
		logic [7:0] write_data;
		logic [1:0] ack_source;
	} item_t;

	typedef struct packed {
		logic [7:0]       read_data;
		logic [IRQ_N-1:0] pending;
	} result_t;

	// Prescaler divisor for a clock select; zero means stopped
	function automatic logic [PRE_W-1:0] reload_of(input logic [2:0] cs);
		logic [PRE_W-1:0] r;
		case (cs)
			3'd1:    r = PRE_W'(1);
			3'd2:    r = PRE_W'(8);
			3'd3:    r = PRE_W'(64);
			3'd4:    r = PRE_W'(256);
			3'd5:    r = PRE_W'(1024);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/t8pc_if.sv
// Valid/ready channel interfaces for the timer: bus item in, result out.
// No dependencies.
interface t8pc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] address;
	logic [7:0] write_data;
	logic [1:0] ack_source;

	modport source (output valid, opcode, address, write_data, ack_source, input ready);
	modport sink   (input valid, opcode, address, write_data, ack_source, output ready);
endinterface

interface t8pc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_overflow;
	logic       irq_compare_a;
	logic       irq_compare_b;

	modport source (output valid, read_data, irq_overflow, irq_compare_a, irq_compare_b,
		input ready);
	modport sink   (input valid, read_data, irq_overflow, irq_compare_a, irq_compare_b,
		output ready);
endinterface

>>> rtl/t8pc_core.sv
// Timer state and single-pass update: registers, prescaler, counter, flags.
// Depends on t8pc_pkg.
module t8pc_core
	import t8pc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t result
);

	logic [7:0]       control_a_q, control_b_q, count_q, compare_a_q, compare_b_q;
	logic [7:0]       flags_q, mask_q;
	logic [IRQ_N-1:0] pending_q;
	logic [PRE_W-1:0] remaining_q;

	logic [7:0]       control_a_d, control_b_d, count_d, compare_a_d, compare_b_d;
	logic [7:0]       flags_d, mask_d;
	logic [IRQ_N-1:0] pending_d;
	logic [PRE_W-1:0] remaining_d;

	logic [2:0]       mode;
	logic [2:0]       clock_sel;
	logic [PRE_W-1:0] reload;
	logic [PRE_W-1:0] rem_dec;
	logic             running, advance;
	logic [7:0]       count_inc;
	logic [IRQ_N-1:0] new_flags;
	logic [IRQ_N-1:0] ack_bit;
	logic [7:0]       rd;

	// Mode and clock select live in the stored control bits
	assign mode      = {control_b_q[3], control_a_q[1:0]};
	assign clock_sel = control_b_q[2:0];
	assign reload    = reload_of(clock_sel);
	assign running   = clock_sel inside {[3'd1:3'd5]};
	assign rem_dec   = (remaining_q != '0) ? remaining_q - PRE_W'(1) : remaining_q;
	assign advance   = running && (rem_dec == '0);
	assign count_inc = count_q + 8'd1;
	assign ack_bit   = (item.ack_source == SRC_OVF)  ? 3'b001 :
	                   (item.ack_source == SRC_CMPA) ? 3'b010 :
	                   (item.ack_source == SRC_CMPB) ? 3'b100 : 3'b000;

	always_comb begin
		control_a_d = control_a_q;
		control_b_d = control_b_q;
		count_d     = count_q;
		compare_a_d = compare_a_q;
		compare_b_d = compare_b_q;
		flags_d     = flags_q;
		mask_d      = mask_q;
		pending_d   = pending_q;
		remaining_d = remaining_q;
		new_flags   = '0;
		rd          = '0;
		case (item.opcode)
			OP_TICK: begin
				if (running) begin
					remaining_d = advance ? reload : rem_dec;
				end
				if (advance && (mode == MODE_NORMAL || mode == MODE_CTC)) begin
					count_d = count_inc;
					if (count_inc == 8'd0) begin
						new_flags[SRC_OVF] = 1'b1;
					end else if (mode == MODE_CTC && count_inc == compare_a_q) begin
						new_flags[SRC_CMPA] = 1'b1;
						count_d = 8'd0;
					end
				end
				if (new_flags != '0) begin
					flags_d   = flags_q | {5'd0, new_flags};
					pending_d = (pending_q & ~mask_q[IRQ_N-1:0])
					          | (flags_d[IRQ_N-1:0] & mask_q[IRQ_N-1:0]);
				end
			end
			OP_WRITE: begin
				case (item.address)
					ADDR_CTRL_A: control_a_d = item.write_data & CTRL_A_KEEP;
					ADDR_CTRL_B: control_b_d = item.write_data & CTRL_B_KEEP;
					ADDR_COUNT:  count_d     = item.write_data;
					ADDR_CMP_A:  compare_a_d = item.write_data;
					ADDR_CMP_B:  compare_b_d = item.write_data;
					ADDR_FLAGS: begin
						flags_d   = item.write_data;
						pending_d = (pending_q & ~mask_q[IRQ_N-1:0])
						          | (item.write_data[IRQ_N-1:0] & mask_q[IRQ_N-1:0]);
					end
					ADDR_MASK: begin
						mask_d    = item.write_data;
						pending_d = (pending_q & ~item.write_data[IRQ_N-1:0])
						          | (flags_q[IRQ_N-1:0] & item.write_data[IRQ_N-1:0]);
					end
					default: ;
				endcase
			end
			OP_READ: begin
				case (item.address)
					ADDR_CTRL_A: rd = control_a_q;
					ADDR_CTRL_B: rd = control_b_q;
					ADDR_COUNT:  rd = count_q;
					ADDR_CMP_A:  rd = compare_a_q;
					ADDR_CMP_B:  rd = compare_b_q;
					ADDR_FLAGS:  rd = flags_q;
					ADDR_MASK:   rd = mask_q;
					default:     rd = '0;
				endcase
			end
			OP_ACK: begin
				flags_d   = flags_q & ~{5'd0, ack_bit};
				pending_d = pending_q & ~ack_bit;
			end
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.pending   = pending_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_a_q <= '0;
			control_b_q <= '0;
			count_q     <= '0;
			compare_a_q <= '0;
			compare_b_q <= '0;
			flags_q     <= '0;
			mask_q      <= '0;
			pending_q   <= '0;
			remaining_q <= '0;
		end else if (step) begin
			control_a_q <= control_a_d;
			control_b_q <= control_b_d;
			count_q     <= count_d;
			compare_a_q <= compare_a_d;
			compare_b_q <= compare_b_d;
			flags_q     <= flags_d;
			mask_q      <= mask_d;
			pending_q   <= pending_d;
			remaining_q <= remaining_d;
		end
	end

`ifndef SYNTH
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(pending_q) && $stable(flags_q) && $stable(count_q))
		else $error("timer state changed without an item");

	a_pre_range: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= PRE_W'(1024))
		else $error("prescaler count beyond largest divisor");

	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.opcode == OP_ACK && item.ack_source == SRC_OVF
		|=> !pending_q[SRC_OVF] && !flags_q[SRC_OVF])
		else $error("overflow acknowledge left flag or pending set");

	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.opcode == OP_READ
		|=> $stable(flags_q) && $stable(pending_q) && $stable(count_q))
		else $error("register read changed timer state");
`endif

endmodule

>>> rtl/t8pc_outbuf.sv
// Result register for the timer: holds one result until the sink takes it.
// Depends on t8pc_pkg and t8pc_result_if.
module t8pc_outbuf
	import t8pc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  result_t               res,
	output logic                  can_load,
	t8pc_result_if.source         out_ch
);

	logic    valid_q;
	result_t res_q;

	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.read_data     = res_q.read_data;
	assign out_ch.irq_overflow  = res_q.pending[SRC_OVF];
	assign out_ch.irq_compare_a = res_q.pending[SRC_CMPA];
	assign out_ch.irq_compare_b = res_q.pending[SRC_CMPB];

endmodule

>>> rtl/timer8_prescaled_ctc_top.sv
// Top level of the prescaled 8-bit CTC timer: input register, core, result register.
// Depends on t8pc_pkg, t8pc_if.sv, t8pc_core and t8pc_outbuf.

// An 8-bit timer/counter with a 1/8/64/256/1024 prescaler, normal and CTC counting and
// three interrupt lines (overflow, compare A, compare B). Each item on item_in is one
// bus operation: a clock tick, a register write, a register read or an interrupt
// acknowledge; each item yields exactly one result on result_out carrying the read byte
// (zero unless a read of a mapped address) and the three pending interrupt bits after
// the operation. The block takes one item per clock cycle while result_out is ready.
// An item is captured in the input register and updates the timer state in a single
// pass once the result register can load; its result lands in the result register at
// that same edge. When result_out stalls, the result register holds and one more item
// waits in the input register before item_in drops ready.
module timer8_prescaled_ctc_top
	import t8pc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	t8pc_item_if.sink     item_in,
	t8pc_result_if.source result_out
);

	logic    valid_s1;
	item_t   item_s1;
	logic    can_load;
	logic    step;
	logic    accept;
	result_t res;

	// Advance the held item whenever the result register can take its result
	assign step          = valid_s1 && can_load;
	assign item_in.ready = !valid_s1 || can_load;
	assign accept        = item_in.valid && item_in.ready;

	// Input register: refill on accept, drop once the item has stepped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode     <= item_in.opcode;
			item_s1.address    <= item_in.address;
			item_s1.write_data <= item_in.write_data;
			item_s1.ack_source <= item_in.ack_source;
		end
	end

	// Timer state and its update for the held item
	t8pc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (res)
	);

	// Result register toward the sink
	t8pc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.can_load (can_load),
		.out_ch   (result_out)
	);

endmodule

>>> dv/tb.sv
// Testbench for timer8_prescaled_ctc_top: drives bus items with bursts and gaps, stalls the
// result side, and checks every result against a cycle-free shadow of the timer state.
// Depends on t8pc_pkg, t8pc_if.sv and the timer RTL.
`timescale 1ns / 100ps

module tb;
	import t8pc_pkg::*;

	// Clock select codes of control B bits 2:0
	localparam logic [2:0] CS_STOP     = 3'd0;
	localparam logic [2:0] CS_DIV1     = 3'd1;
	localparam logic [2:0] CS_DIV8     = 3'd2;
	localparam logic [2:0] CS_DIV64    = 3'd3;
	localparam logic [2:0] CS_DIV256   = 3'd4;
	localparam logic [2:0] CS_DIV1024  = 3'd5;
	localparam logic [2:0] CS_EXT_FALL = 3'd6;
	localparam logic [2:0] CS_EXT_RISE = 3'd7;

	// A PWM mode: prescaler runs, count holds
	localparam logic [2:0] MODE_PWM_PC = 3'd1;

	// Acknowledge source with no interrupt behind it
	localparam logic [1:0] SRC_NONE = 2'd3;

	// An address outside the register map
	localparam logic [7:0] ADDR_UNMAPPED = 8'h00;

	localparam int unsigned DIRECTED_ITEMS = 32;
	localparam int unsigned RANDOM_ITEMS   = 500;
	localparam int unsigned DRAIN_CYCLES   = 16;
	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam logic [15:0] RX_PATTERN     = 16'b1101_0011_1011_0001;

	// Shadow of the timer registers; predicts one result per accepted bus item
	class timer_shadow;
		logic [7:0]       ctrl_a, ctrl_b, cnt, ocr_a, ocr_b, flag_reg, mask_reg;
		logic [2:0]       mode, csel, irq;
		logic [PRE_W-1:0] pre_reload, pre_left;
		result_t          replies[$];
		int unsigned      errors;

		function new();
			ctrl_a = '0; ctrl_b = '0; cnt = '0; ocr_a = '0; ocr_b = '0;
			flag_reg = '0; mask_reg = '0; mode = MODE_NORMAL; csel = CS_STOP;
			irq = '0; pre_reload = '0; pre_left = '0; errors = 0;
		endfunction

		// Enabled sources follow their flag, disabled ones hold their pending bit
		function void sync_irq();
			irq = (irq & ~mask_reg[2:0]) | (flag_reg[2:0] & mask_reg[2:0]);
		endfunction

		function void tick();
			logic [2:0] hit;
			hit = '0;
			if (csel < CS_DIV1 || csel > CS_DIV1024)
				return;
			if (pre_left != 0)
				pre_left = pre_left - 1'b1;
			if (pre_left != 0 || pre_reload == 0)
				return;
			pre_left = pre_reload;
			if (mode == MODE_NORMAL) begin
				cnt = cnt + 8'd1;
				if (cnt == 8'd0)
					hit[SRC_OVF] = 1'b1;
			end else if (mode == MODE_CTC) begin
				cnt = cnt + 8'd1;
				if (cnt == 8'd0) begin
					hit[SRC_OVF] = 1'b1;
				end else if (cnt == ocr_a) begin
					hit[SRC_CMPA] = 1'b1;
					cnt = 8'd0;
				end
			end
			if (hit != 0) begin
				flag_reg = flag_reg | {5'd0, hit};
				sync_irq();
			end
		endfunction

		function void store(logic [7:0] adr, logic [7:0] dat);
			case (adr)
				ADDR_CTRL_A: begin
					mode[1:0] = dat[1:0];
					ctrl_a = dat & CTRL_A_KEEP;
				end
				ADDR_CTRL_B: begin
					mode[2] = dat[3];
					csel = dat[2:0];
					case (csel)
						CS_DIV1:    pre_reload = PRE_W'(1);
						CS_DIV8:    pre_reload = PRE_W'(8);
						CS_DIV64:   pre_reload = PRE_W'(64);
						CS_DIV256:  pre_reload = PRE_W'(256);
						CS_DIV1024: pre_reload = PRE_W'(1024);
						default:    pre_reload = '0;
					endcase
					ctrl_b = dat & CTRL_B_KEEP;
				end
				ADDR_COUNT: cnt = dat;
				ADDR_CMP_A: ocr_a = dat;
				ADDR_CMP_B: ocr_b = dat;
				ADDR_FLAGS: begin
					flag_reg = dat;
					sync_irq();
				end
				ADDR_MASK: begin
					mask_reg = dat;
					sync_irq();
				end
				default: ;
			endcase
		endfunction

		function logic [7:0] fetch(logic [7:0] adr);
			case (adr)
				ADDR_CTRL_A: return ctrl_a;
				ADDR_CTRL_B: return ctrl_b;
				ADDR_COUNT:  return cnt;
				ADDR_CMP_A:  return ocr_a;
				ADDR_CMP_B:  return ocr_b;
				ADDR_FLAGS:  return flag_reg;
				ADDR_MASK:   return mask_reg;
				default:     return 8'd0;
			endcase
		endfunction

		// Advance the shadow by one accepted item and queue its result
		function void apply_bus_op(item_t it);
			result_t r;
			r.read_data = 8'd0;
			case (it.opcode)
				OP_TICK:  tick();
				OP_WRITE: store(it.address, it.write_data);
				OP_READ:  r.read_data = fetch(it.address);
				OP_ACK: begin
					if (it.ack_source != SRC_NONE) begin
						flag_reg[it.ack_source] = 1'b0;
						irq[it.ack_source] = 1'b0;
					end
				end
				default: ;
			endcase
			r.pending = irq;
			replies.push_back(r);
		endfunction

		function void check_reply(logic [7:0] rd, logic ovf, logic cmpa, logic cmpb);
			result_t want;
			if (replies.size() == 0) begin
				$error("result with nothing outstanding: read_data %0h", rd);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (rd !== want.read_data) begin
				$error("read_data: expected %0h, got %0h", want.read_data, rd);
				errors++;
			end
			if (ovf !== want.pending[SRC_OVF]) begin
				$error("irq_overflow: expected %0b, got %0b", want.pending[SRC_OVF], ovf);
				errors++;
			end
			if (cmpa !== want.pending[SRC_CMPA]) begin
				$error("irq_compare_a: expected %0b, got %0b", want.pending[SRC_CMPA], cmpa);
				errors++;
			end
			if (cmpb !== want.pending[SRC_CMPB]) begin
				$error("irq_compare_b: expected %0b, got %0b", want.pending[SRC_CMPB], cmpb);
				errors++;
			end
		endfunction
	endclass

	bit   clk;
	logic arst_n;

	t8pc_item_if   item_bus ();
	t8pc_result_if res_bus ();

	timer_shadow shadow = new();

	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned cycles;

	timer8_prescaled_ctc_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_bus),
		.result_out (res_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one item, honoring the burst/gap pattern. Call at a falling edge; returns at the
	// falling edge after acceptance with valid still high, so back-to-back items never
	// drop valid inside a burst.
	task automatic issue(input logic [1:0] op, input logic [7:0] adr, input logic [7:0] dat,
		input logic [1:0] src);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// about a third of the bursts follow straight on, the rest after a gap
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				item_bus.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item_bus.valid      = 1'b1;
		item_bus.opcode     = op;
		item_bus.address    = adr;
		item_bus.write_data = dat;
		item_bus.ack_source = src;
		do
			@(posedge clk);
		while (!item_bus.ready);
		shadow.apply_bus_op(item_t'{opcode: op, address: adr, write_data: dat,
			ack_source: src});
		items_sent++;
		@(negedge clk);
	endtask

	// Unused fields carry random bits so every input bit toggles
	task automatic bus_write(input logic [7:0] adr, input logic [7:0] dat);
		issue(OP_WRITE, adr, dat, 2'($urandom));
	endtask

	task automatic bus_read(input logic [7:0] adr);
		issue(OP_READ, adr, 8'($urandom), 2'($urandom));
	endtask

	task automatic bus_ack(input logic [1:0] src);
		issue(OP_ACK, 8'($urandom), 8'($urandom), src);
	endtask

	task automatic ticks(input int unsigned n);
		repeat (n) issue(OP_TICK, 8'($urandom), 8'($urandom), 2'($urandom));
	endtask

	function automatic logic [7:0] pick_reg();
		case ($urandom_range(0, 6))
			0:       return ADDR_FLAGS;
			1:       return ADDR_CTRL_A;
			2:       return ADDR_CTRL_B;
			3:       return ADDR_COUNT;
			4:       return ADDR_CMP_A;
			5:       return ADDR_CMP_B;
			default: return ADDR_MASK;
		endcase
	endfunction

	// Set up a counting mode, then mix ticks with reads, acknowledges and flag/mask writes.
	// Start near the wrap or the compare value so events come quickly.
	task automatic timer_run();
		logic [2:0]  md, cs;
		logic [7:0]  top, start;
		int unsigned k, n;
		k = $urandom_range(0, 9);
		if (k < 4) begin
			md = MODE_NORMAL;
		end else if (k < 9) begin
			md = MODE_CTC;
		end else begin
			do
				md = 3'($urandom);
			while (md == MODE_NORMAL || md == MODE_CTC);
		end
		k = $urandom_range(0, 9);
		if (k < 7) begin
			cs = CS_DIV1;
		end else if (k < 9) begin
			cs = CS_DIV8;
		end else begin
			case ($urandom_range(0, 2))
				0:       cs = CS_STOP;
				1:       cs = CS_EXT_FALL;
				default: cs = CS_EXT_RISE;
			endcase
		end
		k = $urandom_range(0, 9);
		top = (k == 0) ? 8'd0 : (k == 1) ? 8'($urandom) : 8'($urandom_range(1, 12));
		if (md == MODE_CTC && $urandom_range(0, 4) != 0)
			start = 8'($urandom_range(0, top));
		else if ($urandom_range(0, 4) != 0)
			start = 8'($urandom_range(8'hF0, 8'hFF));
		else
			start = 8'($urandom);

		bus_write(ADDR_CTRL_A, {6'($urandom), md[1:0]});
		bus_write(ADDR_CTRL_B, {4'($urandom), md[2], cs});
		bus_write(ADDR_CMP_A, top);
		bus_write(ADDR_COUNT, start);
		bus_write(ADDR_MASK, ($urandom_range(0, 9) < 7) ? (8'($urandom) | 8'h07) : 8'($urandom));

		n = $urandom_range(6, 40);
		repeat (n) begin
			k = $urandom_range(0, 19);
			if (k < 13)
				ticks(1);
			else if (k < 15)
				bus_read(pick_reg());
			else if (k < 18)
				bus_ack(2'($urandom_range(0, 3)));
			else if (k == 18)
				bus_write(ADDR_MASK, 8'($urandom));
			else
				bus_write(ADDR_FLAGS, 8'($urandom));
		end
	endtask

	// Try a slow divisor: prime the prescaler with divide-by-8, run a few ticks under
	// 64/256/1024, then go back to divide-by-1.
	task automatic slow_prescale_probe();
		logic [2:0]  cs;
		int unsigned n;
		bus_write(ADDR_CTRL_B, {4'($urandom), shadow.mode[2], CS_DIV8});
		if (shadow.pre_left < 3)
			ticks((shadow.pre_left == 0) ? 1 : shadow.pre_left);
		case ($urandom_range(0, 2))
			0:       cs = CS_DIV64;
			1:       cs = CS_DIV256;
			default: cs = CS_DIV1024;
		endcase
		n = $urandom_range(1, 6);
		bus_write(ADDR_CTRL_B, {4'($urandom), shadow.mode[2], cs});
		ticks(n);
		bus_read(ADDR_CTRL_B);
		bus_write(ADDR_CTRL_B, {4'($urandom), shadow.mode[2], CS_DIV1});
	endtask

	// Fully random items, half of them aimed at mapped registers
	task automatic bus_noise();
		int unsigned n;
		n = $urandom_range(1, 6);
		repeat (n)
			issue(2'($urandom), ($urandom_range(0, 1) == 0) ? pick_reg() : 8'($urandom),
				8'($urandom), 2'($urandom));
	endtask

	// Sender: reset, directed items, random sequences, then drain and report
	initial begin
		arst_n              = 1'b0;
		item_bus.valid      = 1'b0;
		item_bus.opcode     = OP_TICK;
		item_bus.address    = '0;
		item_bus.write_data = '0;
		item_bus.ack_source = SRC_OVF;
		items_sent          = 0;
		burst_left          = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Stopped counter and reset values
		bus_read(ADDR_CTRL_A);
		ticks(1);
		// Normal mode from 0xFE: wrap raises overflow; unstored control bits (A 3:2, B 5:4) drop
		bus_write(ADDR_MASK, 8'hFF);
		bus_write(ADDR_COUNT, 8'hFE);
		bus_write(ADDR_CTRL_B, 8'hF1);
		bus_write(ADDR_CTRL_A, 8'hFC);
		ticks(2);
		bus_read(ADDR_FLAGS);
		bus_ack(SRC_OVF);
		bus_ack(SRC_NONE);
		// CTC: compare match sets flag A and clears the count
		bus_write(ADDR_CTRL_A, {6'd0, MODE_CTC[1:0]});
		bus_write(ADDR_CMP_A, 8'h03);
		bus_write(ADDR_COUNT, 8'h01);
		ticks(2);
		bus_read(ADDR_COUNT);
		// Raw flag write keeps all bits; a disabled source keeps its pending bit
		bus_write(ADDR_FLAGS, 8'hFF);
		bus_ack(SRC_CMPB);
		bus_write(ADDR_MASK, 8'h00);
		bus_write(ADDR_FLAGS, 8'h00);
		bus_read(ADDR_FLAGS);
		// PWM mode: prescaler runs, count holds
		bus_write(ADDR_CTRL_A, {6'd0, MODE_PWM_PC[1:0]});
		ticks(1);
		// External clock selects freeze everything
		bus_write(ADDR_CTRL_B, {4'd0, 1'b0, CS_EXT_RISE});
		ticks(1);
		// Unmapped address: write dropped, read is zero
		bus_write(ADDR_UNMAPPED, 8'hFF);
		bus_read(8'hFF);
		bus_write(ADDR_CMP_B, 8'hFF);
		bus_read(ADDR_CMP_B);

		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			case ($urandom_range(0, 19)) inside
				[0:11]:  timer_run();
				[12:14]: slow_prescale_probe();
				default: bus_noise();
			endcase
		end
		item_bus.valid = 1'b0;

		// Wait for every queued result, then give the pipeline time to show strays
		while (shadow.replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Receiver: phases of always-ready, random and patterned stalls, plus one long hold-off
	// while the sender keeps offering, so the block backs up and drops item_in.ready
	initial begin
		int unsigned phase_left, hold_left, pat_idx;
		int          phase;
		bit          hold_done;
		phase_left = 0;
		hold_left  = 0;
		pat_idx    = 0;
		phase      = 0;
		hold_done  = 1'b0;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= 200) begin
				hold_done = 1'b1;
				hold_left = $urandom_range(40, 64);
			end
			if (hold_left != 0) begin
				hold_left--;
				res_bus.ready = 1'b0;
			end else begin
				if (phase_left == 0) begin
					phase      = $urandom_range(0, 3);
					phase_left = $urandom_range(30, 150);
				end
				phase_left--;
				case (phase)
					0:       res_bus.ready = 1'b1;
					1:       res_bus.ready = ($urandom_range(0, 9) < 7);
					2:       res_bus.ready = RX_PATTERN[pat_idx % 16];
					default: res_bus.ready = ($urandom_range(0, 9) < 2);
				endcase
				pat_idx++;
			end
		end
	end

	// Check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready)
			shadow.check_reply(res_bus.read_data, res_bus.irq_overflow,
				res_bus.irq_compare_a, res_bus.irq_compare_b);
	end

	// Guard against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

endmodule
